// ===== rtl/core/fpar_pkg.sv =====
// ----------------------------------------------------------------------------
// fpar_pkg: shared definitions for the area-averaging audio resampler
// widths, register map, reset values, sequencer states and divider status
// ----------------------------------------------------------------------------
package fpar_pkg;

	// defaults for the top-level parameters
	localparam int FRAC_BITS_DEF   = 15;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed port and datapath widths
	localparam int SMP_W  = 16;
	localparam int STEP_W = 21;
	localparam int LEN_W  = 16;
	localparam int ACC_W  = 32;
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// register reset values
	localparam logic [STEP_W-1:0] RATE_STEP_RST  = STEP_W'(32768);
	localparam logic [LEN_W-1:0]  OUT_LENGTH_RST = LEN_W'(1024);

	// register map, word index = paddr[2]
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_RATE_STEP  = 1'b0;
	localparam reg_idx_t REG_OUT_LENGTH = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ACC,
		ST_AVG,
		ST_EMIT_AVG,
		ST_DIV_WAIT,
		ST_BASE,
		ST_LOOP,
		ST_SCALE
	} fsm_state_t;

	// serial divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/fpar_in_if.sv =====
// ----------------------------------------------------------------------------
// fpar_in_if: input sample channel
// valid/ready handshake carrying one input sample and its buffer start flag
// ----------------------------------------------------------------------------
interface fpar_in_if
	import fpar_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] in_sample;
	logic                    buffer_start;

	modport source (output valid, output in_sample, output buffer_start, input ready);
	modport sink   (input valid, input in_sample, input buffer_start, output ready);
endinterface

// ===== rtl/core/fpar_out_if.sv =====
// ----------------------------------------------------------------------------
// fpar_out_if: resampled output channel
// valid/ready handshake carrying one output sample and its marker flags
// ----------------------------------------------------------------------------
interface fpar_out_if
	import fpar_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] out_sample;
	logic                    run_last;
	logic                    buffer_done;

	modport source (output valid, output out_sample, output run_last, output buffer_done,
		input ready);
	modport sink   (input valid, input out_sample, input run_last, input buffer_done,
		output ready);
endinterface

// ===== rtl/core/fixed_point_area_audio_resampler_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_area_audio_resampler_core: mono area-averaging resampler
// Q15 fixed-point rate converter with area averaging and linear interpolation
// ----------------------------------------------------------------------------
// Usage: each input word carries the next mono sample; the core holds one
// sample and processes it when the following word arrives, since that word is
// the interpolation neighbor. A word with buffer_start set clears the state,
// stores its sample and produces nothing. When the phase crosses zero the core
// emits the area average collected so far, then linearly interpolated samples
// until the phase goes negative again; run_last marks the last output word of
// an input word and buffer_done the out_length-th output of the buffer, after
// which words without buffer_start are taken and dropped. The core takes no
// new word while it works on one: a word that crosses zero and does not end
// the buffer on its average waits for the bit-serial slope divider, and stalls
// on the output hold the core as well.
// All multiplications run through one shared 32 x (FRAC_BITS+6) multiplier
// with a registered product. rate_step (word 0) and out_length (word 1) are
// written over the APB port; the user must write them only while the core is
// idle, the core itself does not enforce this.
// ----------------------------------------------------------------------------
module fixed_point_area_audio_resampler_core
	import fpar_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fpar_in_if.sink           stream,
	fpar_out_if.source        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);
	// derived widths and constants
	localparam int DELTA_W = FRAC_BITS + 6;           // holds the clamped step
	localparam int PH_W    = FRAC_BITS + 8;           // signed phase
	localparam int NUM_W   = SAMPLE_BITS + 1 + FRAC_BITS;
	localparam logic [STEP_W-1:0]    STEP_MAX = STEP_W'(63) << FRAC_BITS;
	localparam logic signed [PH_W-1:0] ONE_PH = PH_W'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0]   ONE_F    = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	// config registers
	logic [STEP_W-1:0] rate_step_q;
	logic [LEN_W-1:0]  out_length_q;

	// sequencer and state
	fsm_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] nx_q;
	logic [DELTA_W-1:0]            delta_q;
	logic signed [PH_W-1:0]        phase_q;
	logic [FRAC_BITS-1:0]          frac_q;
	logic [ACC_W-1:0]              area_q;
	logic [ACC_W-1:0]              dl_q;
	logic [LEN_W-1:0]              emitted_q;
	logic                          finished_q;

	// shared multiplier
	logic [ACC_W-1:0]   mul_a;
	logic [DELTA_W-1:0] mul_b;
	logic [ACC_W-1:0]   prod_q;

	// output register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic                    out_last_q;
	logic                    out_done_q;

	// divider hookup
	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [ACC_W-1:0]        div_quot;
	div_stat_t               div_stat;
	logic signed [SAMPLE_BITS:0] diff;

	// misc combinational
	logic                          in_fire;
	logic                          cfg_wr;
	logic signed [SAMPLE_BITS-1:0] nx_in;
	logic [DELTA_W-1:0]            delta_c;
	logic signed [PH_W-1:0]        ph_dec;
	logic [FRAC_BITS:0]            one_minus;
	logic [ACC_W-1:0]              r32;
	logic [ACC_W-1:0]              avg;
	logic [ACC_W-1:0]              dl_frac;
	logic [LEN_W-1:0]              cnt_nx;
	logic                          fin_nx;
	logic                          slot_free;
	logic                          emit;
	logic [ACC_W-1:0]              emit_val;
	logic                          emit_last;
	logic signed [SAMPLE_BITS-1:0] emit_w;

	// ------------------------------------------------------------------
	// config port, word index from paddr[2]
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_step_q  <= RATE_STEP_RST;
			out_length_q <= OUT_LENGTH_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_RATE_STEP:  rate_step_q  <= pwdata[STEP_W-1:0];
				REG_OUT_LENGTH: out_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_RATE_STEP:  prdata = APB_DW'(rate_step_q);
			REG_OUT_LENGTH: prdata = APB_DW'(out_length_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// per-word helpers
	// ------------------------------------------------------------------
	assign in_fire = stream.valid & stream.ready;
	assign nx_in   = stream.in_sample[SAMPLE_BITS-1:0];

	// step clamped to 1 LSB .. 63 output periods per input
	always_comb begin
		if (rate_step_q == '0)
			delta_c = DELTA_W'(1);
		else if (rate_step_q > STEP_MAX)
			delta_c = STEP_MAX[DELTA_W-1:0];
		else
			delta_c = rate_step_q[DELTA_W-1:0];
	end

	assign ph_dec    = phase_q - ONE_PH;
	assign one_minus = ONE_F - {1'b0, frac_q};
	assign r32       = ACC_W'(held_q);
	assign avg       = ACC_W'($signed(area_q) >>> FRAC_BITS);
	assign dl_frac   = ACC_W'($signed(prod_q) >>> FRAC_BITS);
	assign cnt_nx    = emitted_q + LEN_W'(1);
	assign fin_nx    = (cnt_nx >= out_length_q);
	assign slot_free = ~out_valid_q | result.ready;

	// slope numerator (next - held) << FRAC_BITS
	assign diff    = {nx_q[SAMPLE_BITS-1], nx_q} - {held_q[SAMPLE_BITS-1], held_q};
	assign div_num = {diff, {FRAC_BITS{1'b0}}};

	fpar_div #(
		.NUM_W (NUM_W),
		.DEN_W (DELTA_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (delta_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	// ------------------------------------------------------------------
	// sequencer: next state, emit strobe and multiplier operands
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_val  = area_q;
		emit_last = 1'b0;
		div_start = 1'b0;
		mul_a     = r32;
		mul_b     = DELTA_W'(one_minus);
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !stream.buffer_start && !finished_q)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				// crossing: weight held sample by remaining area, else by full step
				if (phase_q[PH_W-1]) begin
					mul_b   = delta_q;
					state_d = ST_ACC;
				end else begin
					state_d = ST_AVG;
				end
			end
			ST_ACC: state_d = ST_IDLE;
			ST_AVG: begin
				div_start = 1'b1;
				state_d   = ST_EMIT_AVG;
			end
			ST_EMIT_AVG: begin
				emit_val  = avg;
				emit_last = fin_nx | phase_q[PH_W-1];
				if (slot_free) begin
					emit    = 1'b1;
					state_d = fin_nx ? ST_IDLE : ST_DIV_WAIT;
				end
			end
			ST_DIV_WAIT: begin
				// slope times old fraction, for the interpolation base
				mul_a = div_quot;
				mul_b = DELTA_W'(frac_q);
				if (div_stat.done)
					state_d = ST_BASE;
			end
			ST_BASE: state_d = ST_LOOP;
			ST_LOOP: begin
				// on exit, scale the running value by the new fraction
				mul_a = area_q;
				mul_b = DELTA_W'(phase_q[FRAC_BITS-1:0]);
				if (!phase_q[PH_W-1]) begin
					emit_last = fin_nx | ph_dec[PH_W-1];
					if (slot_free) begin
						emit = 1'b1;
						if (fin_nx)
							state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// shared multiplier, low word of the product registered every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a * ACC_W'(mul_b);
	end

	// ------------------------------------------------------------------
	// resampler state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			phase_q    <= -ONE_PH;
			frac_q     <= '0;
			area_q     <= '0;
			emitted_q  <= '0;
			finished_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && stream.buffer_start) begin
						// start of buffer: clear and keep this sample only
						held_q     <= nx_in;
						phase_q    <= -ONE_PH;
						frac_q     <= '0;
						area_q     <= '0;
						emitted_q  <= '0;
						finished_q <= 1'b0;
					end else if (in_fire && !finished_q) begin
						phase_q <= phase_q + PH_W'(delta_c);
					end
				end
				ST_CHECK: begin
					if (phase_q[PH_W-1])
						frac_q <= phase_q[FRAC_BITS-1:0];
					else
						phase_q <= ph_dec;
				end
				ST_ACC: begin
					area_q <= area_q + prod_q;
					held_q <= nx_q;
				end
				ST_AVG: area_q <= area_q + prod_q;
				ST_EMIT_AVG: begin
					if (emit) begin
						emitted_q <= cnt_nx;
						if (fin_nx)
							finished_q <= 1'b1;
					end
				end
				ST_BASE: area_q <= r32 + dl_q - dl_frac;
				ST_LOOP: begin
					if (!phase_q[PH_W-1]) begin
						if (emit) begin
							emitted_q <= cnt_nx;
							if (fin_nx) begin
								finished_q <= 1'b1;
							end else begin
								area_q  <= area_q + dl_q;
								phase_q <= ph_dec;
							end
						end
					end else begin
						frac_q <= phase_q[FRAC_BITS-1:0];
					end
				end
				ST_SCALE: begin
					area_q <= prod_q;
					held_q <= nx_q;
				end
				default: ;
			endcase
		end
	end

	// per-word payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			nx_q    <= nx_in;
			delta_q <= delta_c;
		end
		if (state_q == ST_DIV_WAIT && div_stat.done)
			dl_q <= div_quot;
	end

	// ------------------------------------------------------------------
	// output register, wraps to SAMPLE_BITS and sign-extends
	// ------------------------------------------------------------------
	assign emit_w = emit_val[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_sample_q <= SMP_W'(emit_w);
			out_last_q   <= emit_last;
			out_done_q   <= fin_nx;
		end
	end

	assign stream.ready       = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.out_sample  = out_sample_q;
	assign result.run_last    = out_last_q;
	assign result.buffer_done = out_done_q;

`ifndef SYNTHESIS
	// nothing is emitted once the buffer is done
	a_no_emit_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !finished_q)
		else $error("output emitted after buffer done");

	// a start word leaves the core idle with a fresh count
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && stream.buffer_start) |=>
			(emitted_q == '0 && !finished_q && state_q == ST_IDLE))
		else $error("buffer start did not clear the state");

	// between words of a live buffer the phase is negative
	a_phase_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !finished_q) |-> phase_q[PH_W-1])
		else $error("phase not negative while idle");

	// the slope is only used after the divider has finished
	a_div_before_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE) |-> ($past(div_stat.done) && !div_stat.busy))
		else $error("interpolation base formed before divide completed");
`endif

endmodule

// ===== rtl/core/fpar_div.sv =====
// ----------------------------------------------------------------------------
// fpar_div: bit-serial signed divider
// restoring division of a signed dividend by a positive divisor, one quotient
// bit per cycle, quotient truncated toward zero
// ----------------------------------------------------------------------------
module fpar_div
	import fpar_pkg::*;
#(
	parameter int NUM_W = 32,
	parameter int DEN_W = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  dividend,
	input  logic [DEN_W-1:0]  divisor,
	output logic [ACC_W-1:0]  quotient,
	output div_stat_t         stat
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]          trial;
	logic [DEN_W:0]          trial_sub;
	logic                    fits;
	logic signed [NUM_W-1:0] quot_s;

	assign trial     = {rem_q, mag_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});

	// payload side, quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[NUM_W-1] ? (~dividend + NUM_W'(1)) : dividend;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quot_s      = neg_q ? (~mag_q + NUM_W'(1)) : mag_q;
	assign quotient    = ACC_W'(quot_s);
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;

endmodule

// ===== tb/fixed_point_area_audio_resampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// fixed_point_area_audio_resampler_core_tb: self-checking bench for the resampler
// drives sample streams and register settings into the core, predicts every
// output word with a bit-accurate Q15 model and compares each word field by field
// ----------------------------------------------------------------------------
module fixed_point_area_audio_resampler_core_tb;
	import fpar_pkg::*;

	// timing
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;

	// Q15 arithmetic constants
	localparam int ONE_Q     = 1 << FRAC_BITS_DEF;
	localparam int FRAC_MASK = ONE_Q - 1;
	localparam int STEP_CAP  = 63 << FRAC_BITS_DEF;
	localparam int STEP_TOP  = (1 << STEP_W) - 1;

	typedef struct packed {
		logic signed [SMP_W-1:0] smp;
		logic                    run_last;
		logic                    buffer_done;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n;

	// apb port
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	fpar_in_if  in_ch();
	fpar_out_if out_ch();

	fixed_point_area_audio_resampler_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (in_ch),
		.result  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// register copies as the core should hold them
	logic [STEP_W-1:0] cfg_step = RATE_STEP_RST;
	logic [LEN_W-1:0]  cfg_len  = OUT_LENGTH_RST;

	// resampler state, reset values
	int          held_smp  = 0;
	int          phase_acc = -ONE_Q;
	int          frac      = 0;
	bit [31:0]   area      = '0;
	bit [15:0]   emitted   = '0;
	bit          stopped   = 1'b0;

	out_word_t   run_words[$];       // words caused by the current input word
	out_word_t   pending_outputs[$]; // predicted words not yet seen

	int mismatches   = 0;
	int sent_items   = 0; // input words accepted by the core
	int cycle_count  = 0;
	int src_idle_pct = 0;
	int stall_pct    = 0;
	int hold_left    = 0;

	// one output of the resampler: wrap to 16 bits, count it, flag buffer end
	function automatic void emit_sample(bit [31:0] v);
		out_word_t w;
		emitted       = emitted + 16'd1;
		w.smp         = v[SMP_W-1:0];
		w.run_last    = 1'b0;
		w.buffer_done = (emitted >= cfg_len);
		if (w.buffer_done)
			stopped = 1'b1;
		run_words.push_back(w);
	endfunction

	// advance the resampler by one input word and queue the words it causes;
	// returns 0 when the word is dropped because the buffer is done
	function automatic bit resample_input(logic signed [SMP_W-1:0] smp, logic start);
		int        r;
		int        nx;
		int        num;
		int        dl;
		bit [31:0] delta;
		bit [31:0] prod;
		out_word_t w;
		run_words.delete();
		if (start) begin
			// buffer start: clear everything, only keep the sample
			held_smp  = int'(smp);
			phase_acc = -ONE_Q;
			frac      = 0;
			area      = '0;
			emitted   = '0;
			stopped   = 1'b0;
			return 1'b1;
		end
		if (stopped)
			return 1'b0;
		// zero step acts as one, oversize step saturates
		delta = 32'(cfg_step);
		if (delta == 0)
			delta = 1;
		if (delta > STEP_CAP)
			delta = STEP_CAP;
		r         = held_smp;
		nx        = int'(smp);
		phase_acc = phase_acc + int'(delta);
		if (phase_acc >= 0) begin
			// phase crossed zero: area average first
			phase_acc = phase_acc - ONE_Q;
			area      = area + (ONE_Q - frac) * r;
			emit_sample($signed(area) >>> FRAC_BITS_DEF);
			if (!stopped) begin
				// slope toward the neighbor sample, truncated toward zero
				num  = (nx - r) <<< FRAC_BITS_DEF;
				dl   = num / int'(delta);
				prod = dl * frac;
				area = r + dl - ($signed(prod) >>> FRAC_BITS_DEF);
				while (phase_acc >= 0) begin
					emit_sample(area);
					if (stopped)
						break;
					area      = area + dl;
					phase_acc = phase_acc - ONE_Q;
				end
				if (!stopped) begin
					frac = phase_acc & FRAC_MASK;
					area = area * frac;
				end
			end
		end else begin
			// no crossing: keep collecting area
			frac = phase_acc & FRAC_MASK;
			area = area + r * delta;
		end
		if (!stopped)
			held_smp = nx;
		for (int i = 0; i < run_words.size(); i++) begin
			w          = run_words[i];
			w.run_last = (i == run_words.size() - 1);
			pending_outputs.push_back(w);
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
	endtask

	// watch both channels; predict on accepted input words, check output words
	always @(posedge clk) begin : watch_words
		out_word_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				void'(resample_input(in_ch.in_sample, in_ch.buffer_start));
			if (out_ch.valid && out_ch.ready) begin
				if (pending_outputs.size() == 0) begin
					report_mismatch("output word with nothing pending",
						int'(out_ch.out_sample), 0);
				end else begin
					want = pending_outputs.pop_front();
					if (out_ch.out_sample !== want.smp)
						report_mismatch("out_sample", int'(out_ch.out_sample),
							int'(want.smp));
					if (out_ch.run_last !== want.run_last)
						report_mismatch("run_last", int'(out_ch.run_last),
							int'(want.run_last));
					if (out_ch.buffer_done !== want.buffer_done)
						report_mismatch("buffer_done", int'(out_ch.buffer_done),
							int'(want.buffer_done));
				end
			end
		end
	end

	// long output hold-off, counted down on its own
	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// output ready: random stalls, forced low during a hold-off
	always @(negedge clk) begin
		out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// offer one input word, with random idle cycles ahead of it; called and
	// returns at a falling edge, valid stays high for a back-to-back word
	task automatic send_sample(logic signed [SMP_W-1:0] smp, logic start);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.in_sample    <= smp;
		in_ch.buffer_start <= start;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent_items++;
		@(negedge clk);
	endtask

	// stop offering, wait for every predicted word, then let the core settle
	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
	endtask

	// apb write followed by a read back of the same register
	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_RATE_STEP)
			cfg_step = value[STEP_W-1:0];
		else
			cfg_len = value[LEN_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = (idx == REG_RATE_STEP) ? APB_DW'(cfg_step) : APB_DW'(cfg_len);
		if (prdata !== want)
			report_mismatch("register read back", prdata, want);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// reset values, no buffer start: held sample begins at zero
	task automatic test_no_start_after_reset();
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shffff, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh3039, 1'b0);
		drain_outputs();
	endtask

	// zero step behaves as one, oversize step saturates at 63 outputs per word
	task automatic test_rate_step_limits();
		write_reg(REG_RATE_STEP, 0);
		write_reg(REG_OUT_LENGTH, 32'hffff);
		send_sample(16'sd100, 1'b1);
		send_sample(16'sd200, 1'b0);
		send_sample(-16'sd300, 1'b0);
		drain_outputs();
		write_reg(REG_RATE_STEP, STEP_TOP);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		drain_outputs();
	endtask

	// zero length, buffer ending inside a run, length lowered below the count
	task automatic test_out_length_limits();
		write_reg(REG_RATE_STEP, ONE_Q);
		write_reg(REG_OUT_LENGTH, 0);
		send_sample(16'sd5, 1'b1);
		send_sample(16'sd1000, 1'b0);
		send_sample(16'sd2000, 1'b0);
		drain_outputs();
		// ends in the middle of the second word's interpolation run
		write_reg(REG_RATE_STEP, 5 * ONE_Q);
		write_reg(REG_OUT_LENGTH, 7);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd100, 1'b0);
		drain_outputs();
		write_reg(REG_RATE_STEP, ONE_Q);
		write_reg(REG_OUT_LENGTH, 1000);
		send_sample(-16'sd7, 1'b1);
		repeat (4)
			send_sample(SMP_W'($urandom), 1'b0);
		drain_outputs();
		write_reg(REG_OUT_LENGTH, 2);
		send_sample(16'sd42, 1'b0);
		send_sample(16'sd43, 1'b0);
		drain_outputs();
	endtask

	// receiver holds off while many words are offered, core must stall input
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		stall_pct    = 0;
		write_reg(REG_RATE_STEP, 8 * ONE_Q);
		write_reg(REG_OUT_LENGTH, 32'hffff);
		hold_left <= HOLD_CYCLES;
		send_sample(SMP_W'($urandom), 1'b1);
		repeat (20)
			send_sample(SMP_W'($urandom), 1'b0);
		drain_outputs();
	endtask

	// random buffers with random settings under one idling mix
	task automatic test_random_streams(int idle_pct, int stall, int target);
		logic signed [SMP_W-1:0] level;
		int                      style;
		int                      len;
		int                      first;
		logic [APB_DW-1:0]       step;
		logic [APB_DW-1:0]       olen;
		src_idle_pct = idle_pct;
		stall_pct    = stall;
		for (int seg = 0; seg < 4; seg++) begin
			case ($urandom_range(5))
				0:       step = $urandom_range(0, ONE_Q - 1);
				1, 2:    step = $urandom_range(ONE_Q, 4 * ONE_Q);
				3:       step = $urandom_range(4 * ONE_Q, STEP_CAP);
				4:       step = $urandom_range(STEP_CAP, STEP_TOP);
				default: step = $urandom_range(ONE_Q / 2, 2 * ONE_Q);
			endcase
			case ($urandom_range(7))
				0:       olen = 0;
				1:       olen = 32'hffff;
				default: olen = $urandom_range(1, 200);
			endcase
			write_reg(REG_RATE_STEP, step);
			write_reg(REG_OUT_LENGTH, olen);
			first = sent_items;
			while (sent_items - first < target / 4) begin
				if ($urandom_range(9) == 0) begin
					// stray word, start flag random
					send_sample(SMP_W'($urandom), 1'($urandom_range(1)));
				end else begin
					// well-formed buffer: start word then a run of samples
					style = $urandom_range(2);
					level = SMP_W'($urandom);
					len   = $urandom_range(4, 40);
					send_sample(level, 1'b1);
					repeat (len) begin
						case (style)
							0:       level = SMP_W'($urandom);
							1:       level = level + SMP_W'($urandom_range(2047)) - 16'sd1024;
							default: level = level[SMP_W-1] ? 16'sh7fff : 16'sh8000;
						endcase
						send_sample(level, 1'b0);
					end
				end
			end
			drain_outputs();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.in_sample    = '0;
		in_ch.buffer_start = 1'b0;
		out_ch.ready       = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_no_start_after_reset();
		test_rate_step_limits();
		test_out_length_limits();
		test_output_backpressure();
		test_random_streams(0, 0, 60);
		test_random_streams(82, 0, 60);
		test_random_streams(0, 82, 60);
		test_random_streams(27, 27, 60);

		if (mismatches == 0 && pending_outputs.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/fpar_pkg.sv
rtl/core/fpar_in_if.sv
rtl/core/fpar_out_if.sv
rtl/core/fpar_div.sv
rtl/core/fixed_point_area_audio_resampler_core.sv
tb/fixed_point_area_audio_resampler_core_tb.sv
